// ===== sv/ilqe_pkg.sv =====
package ilqe_pkg;

   // Element and arithmetic widths.
   localparam int DataW    = 64;
   localparam int StepW    = 63;
   localparam int NumW     = DataW + 1;
   localparam int DivSteps = NumW;

   // Element width codes, taken from the low two bits of the element type.
   localparam logic [1:0] Width8  = 2'd0;
   localparam logic [1:0] Width16 = 2'd1;
   localparam logic [1:0] Width32 = 2'd2;
   localparam logic [1:0] Width64 = 2'd3;

   // Side information that travels with each word through the pipeline.
   typedef struct packed {
      logic       last;
      logic       neg;
      logic [1:0] wcode;
   } side_type;

   // Mask of the bits that belong to an element of the given width.
   function automatic logic [DataW-1:0] width_mask(input logic [1:0] wcode);
      logic [DataW-1:0] mask;
      begin
         case (wcode)
            Width8:  mask = {{(DataW-8){1'b0}}, {8{1'b1}}};
            Width16: mask = {{(DataW-16){1'b0}}, {16{1'b1}}};
            Width32: mask = {{(DataW-32){1'b0}}, {32{1'b1}}};
            default: mask = {DataW{1'b1}};
         endcase
         return mask;
      end
   endfunction

   // Sign bit of an element of the given width.
   function automatic logic sign_of(input logic [1:0] wcode, input logic [DataW-1:0] x);
      logic s;
      begin
         case (wcode)
            Width8:  s = x[7];
            Width16: s = x[15];
            Width32: s = x[31];
            default: s = x[63];
         endcase
         return s;
      end
   endfunction

endpackage

// ===== sv/ilqe_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage, MSB first.
// The user must keep the divisor steady while words are in flight (unchecked).
module ilqe_div
   import ilqe_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [NumW-1:0]     in_num,
   input  side_type            in_side,
   input  logic [StepW-1:0]    divisor,
   output logic                out_valid,
   output logic [DataW-1:0]    out_quot,
   output side_type            out_side
);

   logic                vld_ff  [DivSteps];
   logic [StepW-1:0]    rem_ff  [DivSteps];
   logic [NumW-1:0]     dq_ff   [DivSteps];
   side_type            side_ff [DivSteps];

   genvar k;
   generate
      for (k = 0; k < DivSteps; k++) begin : g_step
         logic             vld_prev;
         logic [StepW-1:0] rem_prev;
         logic [NumW-1:0]  dq_prev;
         side_type         side_prev;
         logic [StepW:0]   shifted;
         logic [StepW+1:0] diff;
         logic             ge;
         logic [StepW-1:0] rem_in;
         logic [NumW-1:0]  dq_in;

         // Previous stage, or the divider inputs for the first step.
         if (k == 0) begin : g_first
            assign vld_prev  = in_valid;
            assign rem_prev  = '0;
            assign dq_prev   = in_num;
            assign side_prev = in_side;
         end else begin : g_next
            assign vld_prev  = vld_ff[k-1];
            assign rem_prev  = rem_ff[k-1];
            assign dq_prev   = dq_ff[k-1];
            assign side_prev = side_ff[k-1];
         end

         // Shift in the next dividend bit and try to subtract the divisor.
         always_comb begin
            shifted = {rem_prev, dq_prev[NumW-1]};
            diff    = {1'b0, shifted} - {2'b00, divisor};
            ge      = ~diff[StepW+1];
            rem_in  = ge ? diff[StepW-1:0] : shifted[StepW-1:0];
            dq_in   = {dq_prev[NumW-2:0], ge};
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[k] <= 1'b0;
            end else if (en) begin
               vld_ff[k] <= vld_prev;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k]  <= rem_in;
               dq_ff[k]   <= dq_in;
               side_ff[k] <= side_prev;
            end
         end
      end
   endgenerate

   assign out_valid = vld_ff[DivSteps-1];
   assign out_quot  = dq_ff[DivSteps-1][DataW-1:0];
   assign out_side  = side_ff[DivSteps-1];

endmodule

// ===== sv/integer_linear_quantize_encoder_unit.sv =====
// Integer linear quantizer. Each word on the req_ stream is an element of the
// type set in element_type (unsigned or signed, 8, 16, 32 or 64 bits) and
// comes out on the rsp_ stream divided by step_size with round to nearest;
// signed elements round half away from zero. A step of zero passes the
// element through. Results leave in order, one for each word, and each word
// passes through three preparation stages (mask, magnitude, half-step add),
// a 65-stage restoring divider that resolves one quotient bit per stage and
// the output register. One word is taken every clock; req_tready falls only
// when the output register and its skid register are both full. The
// registers sit on an APB port at byte addresses 0 and 8 and may only be
// written while no word is in flight.
module integer_linear_quantize_encoder_unit
   import ilqe_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // Input stream.
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DataW-1:0]  req_tdata,   // raw_value[63:0]
   input  logic              req_tlast,   // last_element
   // Result stream.
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DataW-1:0]  rsp_tdata,   // quant_value[63:0]
   output logic              rsp_tlast,   // last_out
   // Register port.
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [3:0]        csr_paddr,
   input  logic [63:0]       csr_pwdata,
   output logic [63:0]       csr_prdata,
   output logic              csr_pready
);

   // Register selected by address bit 3.
   localparam logic RegElementType = 1'b0;
   localparam logic RegStepSize    = 1'b1;

   logic [2:0]        element_type_ff;
   logic [StepW-1:0]  step_size_ff;
   logic              csr_write;
   logic              step_zero;
   logic [StepW-1:0]  divisor;

   logic              en;
   logic              a_vld_ff;
   logic [DataW-1:0]  a_x_ff;
   side_type          a_side_ff;
   side_type          a_side_in;
   logic              b_vld_ff;
   logic [DataW-1:0]  b_mag_ff;
   logic [DataW-1:0]  b_mag_in;
   side_type          b_side_ff;
   logic              c_vld_ff;
   logic [NumW-1:0]   c_num_ff;
   side_type          c_side_ff;

   logic              d_valid;
   logic [DataW-1:0]  d_quot;
   side_type          d_side;
   logic [DataW-1:0]  res_word;

   logic              rsp_vld_ff;
   logic [DataW-1:0]  rsp_data_ff;
   logic              rsp_last_ff;
   logic              skid_vld_ff;
   logic [DataW-1:0]  skid_data_ff;
   logic              skid_last_ff;
   logic              push;
   logic              out_take;

   // Register writes and reads.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         element_type_ff <= '0;
         step_size_ff    <= '0;
      end else if (csr_write) begin
         unique case (csr_paddr[3])
            RegElementType: element_type_ff <= csr_pwdata[2:0];
            RegStepSize:    step_size_ff    <= csr_pwdata[StepW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3])
         RegElementType: csr_prdata = {61'd0, element_type_ff};
         RegStepSize:    csr_prdata = {1'b0, step_size_ff};
         default:        csr_prdata = '0;
      endcase
   end

   // A zero step divides by one, which passes the element through.
   assign step_zero = (step_size_ff == '0);
   assign divisor   = step_zero ? StepW'(1) : step_size_ff;

   // The whole pipeline moves while the skid register is free.
   assign en         = ~skid_vld_ff;
   assign req_tready = en;

   // Stage A: mask the element and note its sign.
   always_comb begin
      a_side_in.last  = req_tlast;
      a_side_in.wcode = element_type_ff[1:0];
      a_side_in.neg   = element_type_ff[2] & ~step_zero
                        & sign_of(element_type_ff[1:0], req_tdata);
   end

   // Stage B: magnitude of the element.
   assign b_mag_in = a_side_ff.neg ? ((~a_x_ff & width_mask(a_side_ff.wcode)) + DataW'(1))
                                   : a_x_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= req_tvalid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_x_ff    <= req_tdata & width_mask(element_type_ff[1:0]);
         a_side_ff <= a_side_in;
         b_mag_ff  <= b_mag_in;
         b_side_ff <= a_side_ff;
         // Stage C: add half a step, exact in 65 bits.
         c_num_ff  <= {1'b0, b_mag_ff} + {{(NumW-StepW+1){1'b0}}, step_size_ff[StepW-1:1]};
         c_side_ff <= b_side_ff;
      end
   end

   ilqe_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (c_vld_ff),
      .in_num    (c_num_ff),
      .in_side   (c_side_ff),
      .divisor   (divisor),
      .out_valid (d_valid),
      .out_quot  (d_quot),
      .out_side  (d_side)
   );

   // Put the sign back and cut the result to the element width.
   assign res_word = (d_side.neg ? (DataW'(0) - d_quot) : d_quot) & width_mask(d_side.wcode);

   // Output register with a skid register behind it.
   assign push     = en & d_valid;
   assign out_take = rsp_vld_ff & rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (out_take) begin
            skid_vld_ff <= 1'b0;
         end
      end else if (~rsp_vld_ff | out_take) begin
         rsp_vld_ff <= push;
      end else if (push) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (out_take) begin
            rsp_data_ff <= skid_data_ff;
            rsp_last_ff <= skid_last_ff;
         end
      end else if (~rsp_vld_ff | out_take) begin
         rsp_data_ff <= res_word;
         rsp_last_ff <= d_side.last;
      end else begin
         skid_data_ff <= res_word;
         skid_last_ff <= d_side.last;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // A word waits in the skid register only behind a full output register.
   assert property (@(posedge clock) disable iff (reset) skid_vld_ff |-> rsp_vld_ff)
      else $error("skid register full while output register empty");

   // Unsigned 8-bit results carry zeros above the element.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !element_type_ff[2] && element_type_ff[1:0] == Width8)
      |-> (rsp_data_ff[DataW-1:8] == '0))
      else $error("8-bit result has bits above the element width");

   // Nothing is presented straight after reset.
   assert property (@(posedge clock) reset |=> !rsp_vld_ff && !skid_vld_ff)
      else $error("result valid after reset");
`endif

endmodule

// ===== tb/tb_integer_linear_quantize_encoder_unit.sv =====
`timescale 1ns / 100ps

module tb_integer_linear_quantize_encoder_unit;
   import ilqe_pkg::*;

   // Element type codes as held in the element_type register.
   typedef enum logic [2:0] {
      ElemU8, ElemU16, ElemU32, ElemU64, ElemS8, ElemS16, ElemS32, ElemS64
   } elem_kind_type;

   // Register byte addresses.
   localparam logic [3:0] AddrElemType = 4'h0;
   localparam logic [3:0] AddrStepSize = 4'h8;

   localparam int NumDirected  = 25;
   localparam int RandomWords  = 640;
   localparam int StallLimit   = 4000;
   localparam int DrainCycles  = 100;
   localparam int HoldCycles   = 300;
   localparam int MaxReports   = 10;
   localparam int LongPhase    = 160;
   localparam logic [62:0] StepMax = {63{1'b1}};

   // One quantized word as it should leave the block.
   typedef struct packed {
      logic [63:0] value;
      logic        last;
   } quant_word_type;

   // One row of the directed table; want is used only where known is set.
   typedef struct packed {
      elem_kind_type kind;
      logic [62:0]   step;
      logic [63:0]   raw;
      logic          last;
      logic          known;
      logic [63:0]   want;
   } stim_row_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [DataW-1:0]  req_tdata;    // raw_value[63:0]
   logic              req_tlast;    // last_element
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [DataW-1:0]  rsp_tdata;    // quant_value[63:0]
   logic              rsp_tlast;    // last_out
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [3:0]        csr_paddr;
   logic [63:0]       csr_pwdata;
   logic [63:0]       csr_prdata;
   logic              csr_pready;

   quant_word_type pending_quants[$];
   elem_kind_type  cur_kind;
   logic [62:0]    cur_step;
   int             words_sent;
   int             quants_seen;
   int             mismatch_count;
   int             quiet_cycles;
   bit             calm;
   bit             long_phase;

   // Directed words: reset defaults, field extremes, every element type, ties that
   // round away from zero, the wide unsigned sum and the most negative 64-bit value.
   stim_row_type directed_rows [NumDirected] = '{
      '{ElemU8,  63'd0, 64'hFFFF_FFFF_FFFF_FFAB, 1'b0, 1'b1, 64'hAB},
      '{ElemU8,  63'd0, 64'h0,                  1'b1, 1'b1, 64'h0},
      '{ElemU8,  63'd1, 64'hFF,                 1'b0, 1'b1, 64'hFF},
      '{ElemU8,  63'd2, 64'hFF,                 1'b1, 1'b1, 64'h80},
      '{ElemU8,  63'd3, 64'h05,                 1'b0, 1'b1, 64'h02},
      '{ElemU8,  63'd255, 64'h7F,               1'b0, 1'b1, 64'h00},
      '{ElemU8,  63'd255, 64'h80,               1'b1, 1'b1, 64'h01},
      '{ElemU64, 63'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
      '{ElemU64, 63'd2, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 64'h8000_0000_0000_0000},
      '{ElemU64, StepMax, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 64'h0},
      '{ElemS64, 63'd2, 64'h8000_0000_0000_0000, 1'b0, 1'b1, 64'hC000_0000_0000_0000},
      '{ElemS64, 63'd1, 64'h8000_0000_0000_0000, 1'b1, 1'b1, 64'h8000_0000_0000_0000},
      '{ElemS64, StepMax, 64'h8000_0000_0000_0000, 1'b0, 1'b0, 64'h0},
      '{ElemS8,  63'd0, 64'h80,                 1'b0, 1'b1, 64'h80},
      '{ElemS8,  63'd1, 64'hFF,                 1'b0, 1'b1, 64'hFF},
      '{ElemS8,  63'd2, 64'hFF,                 1'b1, 1'b1, 64'hFF},
      '{ElemS8,  63'd2, 64'h01,                 1'b0, 1'b1, 64'h01},
      '{ElemS8,  63'd3, 64'hFE,                 1'b0, 1'b1, 64'hFF},
      '{ElemS8,  63'd2, 64'hFFFF_FFFF_FFFF_FF7F, 1'b0, 1'b0, 64'h0},
      '{ElemS16, 63'd4, 64'hFFFF_FFFF_FFFF_FFFA, 1'b1, 1'b1, 64'hFFFE},
      '{ElemS16, 63'd0, 64'hDEAD_BEEF_1234_8000, 1'b0, 1'b1, 64'h8000},
      '{ElemS32, 63'd10, 64'h7FFF_FFFF,         1'b0, 1'b0, 64'h0},
      '{ElemS32, 63'd7, 64'h9000_0000,          1'b1, 1'b0, 64'h0},
      '{ElemU32, StepMax, 64'hFFFF_FFFF,        1'b0, 1'b1, 64'h0},
      '{ElemU16, 63'h1_0000, 64'hFFFF,          1'b1, 1'b1, 64'h1}
   };

   integer_linear_quantize_encoder_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   // Round-to-nearest quantization of one element; signed elements round their
   // magnitude, so ties go away from zero. The sum is formed in 65 bits.
   function automatic logic [63:0] quantize_element(input elem_kind_type kind,
                                                     input logic [62:0] step,
                                                     input logic [63:0] raw);
      int          w;
      logic [63:0] mask;
      logic [63:0] x;
      logic [63:0] mag;
      logic [64:0] q;
      logic        neg;
      w    = 8 << kind[1:0];
      mask = {64{1'b1}} >> (64 - w);
      x    = raw & mask;
      if (step == 63'd0)
         return x;
      neg = kind[2] && ((x >> (w - 1)) & 64'd1) != 64'd0;
      mag = neg ? ((~x & mask) + 64'd1) : x;
      q   = ({1'b0, mag} + {2'b0, step >> 1}) / {2'b0, step};
      return (neg ? (64'd0 - q[63:0]) : q[63:0]) & mask;
   endfunction

   // Random idling, switched off during the calm stretch.
   function automatic bit idle_roll();
      return !calm && $urandom_range(0, 99) < 20;
   endfunction

   // Steps are mostly no wider than the element, so that results stay varied.
   function automatic logic [62:0] random_step(input elem_kind_type kind);
      int          bits;
      logic [62:0] s;
      case ($urandom_range(0, 9))
         0: s = 63'd0;
         1: s = StepMax;
         2: s = 63'd1;
         default: begin
            bits = $urandom_range(1, (8 << kind[1:0]) > 63 ? 63 : (8 << kind[1:0]));
            if ($urandom_range(0, 3) == 0)
               bits = $urandom_range(1, 63);
            s = 63'({$urandom, $urandom});
            s = s & ((63'd1 << bits) - 63'd1);
         end
      endcase
      return s;
   endfunction

   // Random elements with a share of zeros, extremes and exact rounding ties.
   function automatic logic [63:0] random_raw(input elem_kind_type kind,
                                               input logic [62:0] step);
      logic [63:0] r;
      logic [63:0] sign;
      logic [63:0] k;
      sign = 64'd1 << ((8 << kind[1:0]) - 1);
      r    = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: r = 64'd0;
         1: r = {64{1'b1}};
         2: r = (r & ~((sign << 1) - 64'd1)) | sign;
         3: r = sign - 64'd1;
         4, 5: begin
            k = 64'($urandom_range(0, 40));
            r = k * {1'b0, step} + {1'b0, step >> 1};
            if ($urandom_range(0, 1) == 1)
               r = 64'd0 - r;
         end
         default: ;
      endcase
      return r;
   endfunction

   // Register write: the setup phase, then the access phase until pready.
   task automatic csr_write(input logic [3:0] addr, input logic [63:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Waits until every expected word has come back, then sets both registers.
   task automatic apply_config(input elem_kind_type kind, input logic [62:0] step);
      logic [63:0] junk;
      req_tvalid <= 1'b0;
      while (pending_quants.size() != 0)
         @(posedge clock);
      junk = {$urandom, $urandom};
      csr_write(AddrElemType, {junk[63:3], kind});
      csr_write(AddrStepSize, {junk[0], step});
      cur_kind = kind;
      cur_step = step;
   endtask

   // Offers one word until it is taken and records what should come back.
   task automatic send_word(input logic [63:0] raw, input logic last,
                            input logic [63:0] want);
      calm = words_sent >= 300 && words_sent < 420;
      while (idle_roll()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= raw;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      pending_quants.push_back('{value: want, last: last});
      words_sent++;
   endtask

   // Stimulus: reset, the directed table, then random phases of settings.
   initial begin : stimulus
      stim_row_type  row;
      elem_kind_type kind;
      logic [62:0]   step;
      logic [63:0]   raw;
      int            count;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      cur_kind    = ElemU8;
      cur_step    = 63'd0;
      words_sent  = 0;
      calm        = 1'b0;
      long_phase  = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The first rows run on the reset settings; registers change only when a row asks.
      for (int i = 0; i < NumDirected; i++) begin
         row = directed_rows[i];
         if (row.kind != cur_kind || row.step != cur_step)
            apply_config(row.kind, row.step);
         send_word(row.raw, row.last,
                   row.known ? row.want : quantize_element(cur_kind, cur_step, row.raw));
      end

      // Random phases; each one drains before the next setting is written. One
      // long phase gives the result side room to fill the pipeline.
      while (words_sent < NumDirected + RandomWords) begin
         kind = elem_kind_type'($urandom_range(0, 7));
         step = random_step(kind);
         apply_config(kind, step);
         count = $urandom_range(30, 90);
         if (!long_phase && words_sent >= 150) begin
            count      = LongPhase;
            long_phase = 1'b1;
         end
         for (int i = 0; i < count; i++) begin
            raw = random_raw(cur_kind, cur_step);
            send_word(raw, 1'($urandom_range(0, 1)),
                      quantize_element(cur_kind, cur_step, raw));
         end
      end

      // Let the pipeline empty, then keep watching for stray words.
      req_tvalid <= 1'b0;
      while (pending_quants.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0 && pending_quants.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Result side: checks each word against the oldest expectation and drives
   // rsp_tready, including one long hold-off during the long phase.
   initial begin : result_sink
      quant_word_type want;
      int             hold_left;
      bit             hold_done;
      rsp_tready     = 1'b0;
      quants_seen    = 0;
      mismatch_count = 0;
      hold_left      = 0;
      hold_done      = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            quants_seen++;
            if (pending_quants.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MaxReports)
                  $display("Unexpected result word: data %h last %b", rsp_tdata, rsp_tlast);
            end else begin
               want = pending_quants.pop_front();
               if (rsp_tdata !== want.value) begin
                  mismatch_count++;
                  if (mismatch_count <= MaxReports)
                     $display("Word %0d quant_value: expected %h, got %h",
                              quants_seen, want.value, rsp_tdata);
               end
               if (rsp_tlast !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= MaxReports)
                     $display("Word %0d last_out: expected %b, got %b",
                              quants_seen, want.last, rsp_tlast);
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && long_phase && pending_quants.size() >= 10) begin
            hold_done = 1'b1;
            hold_left = HoldCycles;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !idle_roll();
         end
      end
   end

   // Watchdog: ends the run when nothing has been accepted for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
